@@ rtl/apd_pkg.sv @@
// Package for the ASCII packet deframer: transaction types and packet layout constants.
// No dependencies.
package apd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned DATA_N    = 5;
    localparam int unsigned DATA_IX_W = 3;
    localparam int unsigned MOD_W     = 7;

    localparam logic [COUNT_W-1:0] POS_ID0      = 4'd0;
    localparam logic [COUNT_W-1:0] POS_ID1      = 4'd1;
    localparam logic [COUNT_W-1:0] POS_DATA0    = 4'd3;
    localparam logic [COUNT_W-1:0] POS_DATA4    = 4'd7;
    localparam logic [COUNT_W-1:0] POS_SUM_LAST = 4'd8;
    localparam logic [COUNT_W-1:0] POS_CHK0     = 4'd9;
    localparam logic [COUNT_W-1:0] POS_CHK1     = 4'd10;
    localparam logic [COUNT_W-1:0] POS_TERM     = 4'd11;
    localparam logic [COUNT_W-1:0] COUNT_SAT    = 4'd13;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } byte_item_t;

    typedef struct packed {
        logic              packet_valid;
        logic [BYTE_W-1:0] id_first;
        logic [BYTE_W-1:0] id_second;
        logic [BYTE_W-1:0] data_char0;
        logic [BYTE_W-1:0] data_char1;
        logic [BYTE_W-1:0] data_char2;
        logic [BYTE_W-1:0] data_char3;
        logic [BYTE_W-1:0] data_char4;
    } result_item_t;

endpackage

@@ rtl/apd_byte_if.sv @@
// Valid/ready channel carrying one packet byte per transaction.
// Depends on apd_pkg.
interface apd_byte_if import apd_pkg::*;;
    logic       valid;
    logic       ready;
    byte_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/apd_result_if.sv @@
// Valid/ready channel carrying one decoded packet result per transaction.
// Depends on apd_pkg.
interface apd_result_if import apd_pkg::*;;
    logic         valid;
    logic         ready;
    result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ascii_packet_deframer_top.sv @@
// ASCII packet deframer top level: input stage, byte capture, checksum and result stage.
// Depends on apd_pkg, apd_byte_if, apd_result_if.
//
// Usage:
//   byte_ch carries one packet character per transaction, with last_byte set on the
//   final one. result_ch carries one result per packet, produced for the transaction
//   that has last_byte set; other bytes give no result.
//   A packet is valid when it held exactly 12 bytes and the two decimal checksum
//   characters (positions 9 and 10) equal the sum of bytes 0..8 modulo 100. With a
//   wrong length the id and data fields are zero.
//   A last byte sits in the input register, and its result is loaded into the output
//   register when it advances, which waits while an earlier result is still unaccepted.
//   Throughput: one byte per cycle unless a last byte waits on a stalled result; set by
//   the byte capture and the modulo-100 update of the running checksum.
//   Reset clears the byte count, checksum and both pipeline valids; the next byte is
//   taken as position 0. A stalled receiver holds the result register; non-last bytes
//   keep flowing, and a last byte waits in the input register until the result slot
//   frees, which then holds off byte_ch.ready.
module ascii_packet_deframer_top import apd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    apd_byte_if.sink            byte_ch,
    apd_result_if.source        result_ch
);

    logic                 in_vld_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;

    logic [COUNT_W-1:0]   cnt_reg;
    logic [COUNT_W-1:0]   cnt_next;
    logic [MOD_W-1:0]     sum_mod_reg;
    logic [MOD_W-1:0]     sum_mod_next;
    logic [BYTE_W-1:0]    id_reg [2];
    logic [BYTE_W-1:0]    data_reg [DATA_N];
    logic [BYTE_W-1:0]    chk_reg [2];

    logic                 out_vld_reg;
    result_item_t         out_reg;
    result_item_t         out_next;

    logic                 advance;
    logic                 take_in;
    logic                 emit;
    logic [BYTE_W:0]      sum_raw;
    logic                 len_ok;
    logic signed [12:0]   dig0;
    logic signed [12:0]   dig1;
    logic signed [12:0]   sent;
    logic [DATA_IX_W-1:0] data_ix;

    assign advance = in_vld_reg && (!in_last_reg || !out_vld_reg || result_ch.ready);
    assign byte_ch.ready = !in_vld_reg || advance;
    assign take_in = byte_ch.valid && byte_ch.ready;
    assign emit = advance && in_last_reg;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_vld_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= byte_ch.data.byte_in;
            in_last_reg <= byte_ch.data.last_byte;
        end
    end

    // running checksum mod 100
    always_comb
    begin
        sum_raw = {2'b00, sum_mod_reg} + {1'b0, in_byte_reg};
        priority if (sum_raw >= 9'd300)
        begin
            sum_mod_next = MOD_W'(sum_raw - 9'd300);
        end
        else if (sum_raw >= 9'd200)
        begin
            sum_mod_next = MOD_W'(sum_raw - 9'd200);
        end
        else if (sum_raw >= 9'd100)
        begin
            sum_mod_next = MOD_W'(sum_raw - 9'd100);
        end
        else
        begin
            sum_mod_next = MOD_W'(sum_raw);
        end
    end

    assign cnt_next = (cnt_reg < COUNT_SAT) ? cnt_reg + 4'd1 : cnt_reg;
    assign data_ix = DATA_IX_W'(cnt_reg - POS_DATA0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            sum_mod_reg <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                cnt_reg     <= '0;
                sum_mod_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                if (cnt_reg <= POS_SUM_LAST)
                begin
                    sum_mod_reg <= sum_mod_next;
                end
            end
        end
    end

    // field capture; only read when all 12 positions were written
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (cnt_reg == POS_ID0)
            begin
                id_reg[0] <= in_byte_reg;
            end
            if (cnt_reg == POS_ID1)
            begin
                id_reg[1] <= in_byte_reg;
            end
            if (cnt_reg >= POS_DATA0 && cnt_reg <= POS_DATA4)
            begin
                data_reg[data_ix] <= in_byte_reg;
            end
            if (cnt_reg == POS_CHK0)
            begin
                chk_reg[0] <= in_byte_reg;
            end
            if (cnt_reg == POS_CHK1)
            begin
                chk_reg[1] <= in_byte_reg;
            end
        end
    end

    // result
    assign len_ok = (cnt_reg == POS_TERM);
    assign dig0 = $signed({5'b0, chk_reg[0]}) - $signed({5'b0, ASCII_ZERO});
    assign dig1 = $signed({5'b0, chk_reg[1]}) - $signed({5'b0, ASCII_ZERO});
    assign sent = (dig0 <<< 3) + (dig0 <<< 1) + dig1;

    always_comb
    begin
        out_next.packet_valid = len_ok && (sent == $signed({6'b0, sum_mod_reg}));
        out_next.id_first     = len_ok ? id_reg[0]   : '0;
        out_next.id_second    = len_ok ? id_reg[1]   : '0;
        out_next.data_char0   = len_ok ? data_reg[0] : '0;
        out_next.data_char1   = len_ok ? data_reg[1] : '0;
        out_next.data_char2   = len_ok ? data_reg[2] : '0;
        out_next.data_char3   = len_ok ? data_reg[3] : '0;
        out_next.data_char4   = len_ok ? data_reg[4] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign result_ch.valid = out_vld_reg;
    assign result_ch.data  = out_reg;

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_SAT)
        else $error("byte count beyond saturation");

    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_mod_reg < 7'd100)
        else $error("checksum residue out of range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (cnt_reg == '0 && sum_mod_reg == '0 && out_vld_reg))
        else $error("state not cleared after last byte");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(in_vld_reg && in_last_reg))
        else $error("result without a last byte");

endmodule

@@ tb/sv/tb_ascii_packet_deframer_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for ascii_packet_deframer_top: directed and random packets, scoreboard.
// Depends on apd_pkg, apd_byte_if, apd_result_if and the deframer RTL.
module tb_ascii_packet_deframer_top import apd_pkg::*;;

    localparam int PKT_BYTES   = 12;
    localparam int MAX_BYTES   = 20;
    localparam int PHASE_BYTES = 450;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    // Tracks packet state per accepted byte and holds the decoded results still owed.
    class deframe_scoreboard;
        logic [COUNT_W-1:0] pos_count;
        logic [11:0]        sum_acc;
        logic [BYTE_W-1:0]  id_chars [2];
        logic [BYTE_W-1:0]  data_chars [DATA_N];
        logic [BYTE_W-1:0]  chk_chars [2];
        result_item_t       expected_results [$];
        int                 mismatches;
        int                 valid_packets;
        int                 rejected_packets;

        function void clear_packet();
            pos_count = '0;
            sum_acc   = '0;
            id_chars  = '{default: '0};
            data_chars = '{default: '0};
            chk_chars = '{default: '0};
        endfunction

        function void note_byte(byte_item_t item);
            logic [COUNT_W-1:0] pos;
            bit                 len_ok;
            int                 sent;
            int                 calc;
            result_item_t       r;
            pos = pos_count;
            if (pos < COUNT_SAT)
            begin
                if (pos <= POS_SUM_LAST)
                    sum_acc = sum_acc + 12'(item.byte_in);
                if (pos <= POS_ID1)
                    id_chars[pos] = item.byte_in;
                else if (pos >= POS_DATA0 && pos <= POS_DATA4)
                    data_chars[pos - POS_DATA0] = item.byte_in;
                else if (pos == POS_CHK0 || pos == POS_CHK1)
                    chk_chars[pos - POS_CHK0] = item.byte_in;
                pos_count = pos + 1'b1;
            end
            if (!item.last_byte)
                return;
            len_ok = (pos_count == PKT_BYTES);
            sent = (int'(chk_chars[0]) - int'(ASCII_ZERO)) * 10
                 + (int'(chk_chars[1]) - int'(ASCII_ZERO));
            calc = int'(sum_acc % 100);
            r.packet_valid = len_ok && (sent == calc);
            r.id_first     = len_ok ? id_chars[0] : '0;
            r.id_second    = len_ok ? id_chars[1] : '0;
            r.data_char0   = len_ok ? data_chars[0] : '0;
            r.data_char1   = len_ok ? data_chars[1] : '0;
            r.data_char2   = len_ok ? data_chars[2] : '0;
            r.data_char3   = len_ok ? data_chars[3] : '0;
            r.data_char4   = len_ok ? data_chars[4] : '0;
            expected_results.push_back(r);
            if (r.packet_valid)
                valid_packets++;
            else
                rejected_packets++;
            clear_packet();
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want,
                                    logic [BYTE_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("packet_valid", 8'(want.packet_valid), 8'(got.packet_valid));
            compare_field("id_first", want.id_first, got.id_first);
            compare_field("id_second", want.id_second, got.id_second);
            compare_field("data_char0", want.data_char0, got.data_char0);
            compare_field("data_char1", want.data_char1, got.data_char1);
            compare_field("data_char2", want.data_char2, got.data_char2);
            compare_field("data_char3", want.data_char3, got.data_char3);
            compare_field("data_char4", want.data_char4, got.data_char4);
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    apd_byte_if   byte_ch ();
    apd_result_if result_ch ();

    deframe_scoreboard board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int bytes_sent     = 0;

    ascii_packet_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic is_last);
        byte_item_t item;
        item.byte_in   = value;
        item.last_byte = is_last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data  <= item;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        board.note_byte(item);
        bytes_sent++;
    endtask

    // Mostly 12-byte frames, often with a correct checksum; the rest odd lengths or bad digits.
    task automatic send_random_packet();
        logic [BYTE_W-1:0] pkt [MAX_BYTES];
        int                len;
        int                sum;
        int                sel;
        sel = $urandom_range(99);
        if (sel < 70)
            len = PKT_BYTES;
        else if (sel < 85)
            len = $urandom_range(PKT_BYTES - 1, PKT_BYTES + 1);
        else
            len = $urandom_range(1, MAX_BYTES);
        sum = 0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            pkt[i] = 8'($urandom_range(255));
            if (i <= POS_SUM_LAST)
                sum += pkt[i];
        end
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            pkt[POS_CHK0] = ASCII_ZERO + 8'((sum % 100) / 10);
            pkt[POS_CHK1] = ASCII_ZERO + 8'(sum % 10);
        end
        else if (sel < 80)
        begin
            pkt[POS_CHK0] = ASCII_ZERO + 8'($urandom_range(9));
            pkt[POS_CHK1] = ASCII_ZERO + 8'($urandom_range(9));
        end
        for (int i = 0; i < len; i++)
            send_byte(pkt[i], i == len - 1);
    endtask

    initial
    begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                board.check_result(result_ch.data);
            if (hold_len > 0 && !hold_taken)
            begin
                hold_left  = hold_len;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase_start;
        board.clear_packet();
        byte_ch.valid <= 1'b0;
        byte_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-ones frame with checksum 95
        for (int i = 0; i <= POS_SUM_LAST; i++)
            send_byte(8'hFF, 1'b0);
        send_byte(ASCII_ZERO + 8'd9, 1'b0);
        send_byte(ASCII_ZERO + 8'd5, 1'b0);
        send_byte(8'hFF, 1'b1);
        // zero frame, non-digit checksum "1&" whose arithmetic still gives 0
        for (int i = 0; i <= POS_SUM_LAST; i++)
            send_byte(8'h00, 1'b0);
        send_byte(ASCII_ZERO + 8'd1, 1'b0);
        send_byte(8'd38, 1'b0);
        send_byte(8'h00, 1'b1);
        // single-byte frame
        send_byte(8'h00, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_len       = HOLD_CYCLES;
                end
                1:
                begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_packet();
        end
        byte_ch.valid <= 1'b0;

        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in four flow-control mixes, one with a long result hold-off.",
                 bytes_sent);
        $display("Decoded %0d good packets and %0d rejected ones; %0d mismatches.",
                 board.valid_packets, board.rejected_packets, board.mismatches);
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
